>>> src/aabbct_pkg.sv
// shared types and codes for the box table core
package aabbct_pkg;

  typedef enum logic [1:0] {
    FUNC_ADD    = 2'd0,
    FUNC_REMOVE = 2'd1,
    FUNC_QUERY  = 2'd2,
    FUNC_CLEAR  = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_OVERLAP   = 3'd3,
    ST_DONE      = 3'd4
  } status_t;

  localparam int unsigned FIELD_W = 16;

  // controller to datapath
  typedef struct packed {
    logic ld_cmd;
    logic add_wr;
    logic shift_wr;
    logic rd_en;
    logic cnt_inc;
    logic cnt_dec;
    logic cnt_clr;
    logic out_ld;
    logic out_match;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic full;
    logic id_eq;
    logic hit;
  } dp_stat_t;

endpackage

>>> src/aabbct_dp.sv
// datapath: box memory, entry count, query registers and overlap compare
module aabbct_dp #(
  parameter int MAX_BOXES  = 32,
  parameter int COORD_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  aabbct_pkg::dp_cmd_t                 cmd,
  output aabbct_pkg::dp_stat_t                stat,
  input  logic [(MAX_BOXES > 1 ? $clog2(MAX_BOXES) : 1)-1:0] rd_addr,
  input  logic [(MAX_BOXES > 1 ? $clog2(MAX_BOXES) : 1)-1:0] shift_addr,
  output logic [$clog2(MAX_BOXES + 1)-1:0]    cnt,
  input  logic [aabbct_pkg::FIELD_W-1:0]      in_box_id,
  input  logic [aabbct_pkg::FIELD_W-1:0]      in_box_x,
  input  logic [aabbct_pkg::FIELD_W-1:0]      in_box_y,
  input  logic [aabbct_pkg::FIELD_W-1:0]      in_box_width,
  input  logic [aabbct_pkg::FIELD_W-1:0]      in_box_height,
  output logic [aabbct_pkg::FIELD_W-1:0]      match_id
);

  localparam int AW   = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
  localparam int CNTW = $clog2(MAX_BOXES + 1);
  localparam int FW   = aabbct_pkg::FIELD_W;
  // room for a sign-extended corner plus an unsigned size without wrap
  localparam int EW   = COORD_BITS + FW + 2;

  typedef struct packed {
    logic [FW-1:0] id;
    logic [FW-1:0] x;
    logic [FW-1:0] y;
    logic [FW-1:0] w;
    logic [FW-1:0] h;
  } entry_t;

  entry_t            mem [MAX_BOXES];
  entry_t            rd_data_r;
  logic [CNTW-1:0]   cnt_r;
  logic [CNTW-1:0]   cnt_nxt;
  logic [FW-1:0]     key_id_r;
  logic [FW-1:0]     q_x_r;
  logic [FW-1:0]     q_y_r;
  logic [FW-1:0]     q_w_r;
  logic [FW-1:0]     q_h_r;
  logic [FW-1:0]     match_id_r;
  entry_t            add_entry;

  logic signed [EW-1:0] e_x, e_y, e_w, e_h;
  logic signed [EW-1:0] q_x, q_y, q_w, q_h;
  logic                 ovl_x, ovl_y;

  // low COORD_BITS bits of the field, sign extended
  function automatic logic signed [EW-1:0] coord_ext(input logic [FW-1:0] raw);
    logic [COORD_BITS+FW-1:0] wide;
    logic [COORD_BITS-1:0]    c;
    wide = {{COORD_BITS{1'b0}}, raw};
    c    = wide[COORD_BITS-1:0];
    return EW'(signed'(c));
  endfunction

  assign add_entry = '{id: in_box_id, x: in_box_x, y: in_box_y,
                       w: in_box_width, h: in_box_height};

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.cnt_clr) begin
      cnt_nxt = '0;
    end else if (cmd.cnt_inc) begin
      cnt_nxt = cnt_r + CNTW'(1);
    end else if (cmd.cnt_dec) begin
      cnt_nxt = cnt_r - CNTW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.add_wr) begin
      mem[cnt_r[AW-1:0]] <= add_entry;
    end else if (cmd.shift_wr) begin
      mem[shift_addr] <= rd_data_r;
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_cmd) begin
      key_id_r <= in_box_id;
      q_x_r    <= in_box_x;
      q_y_r    <= in_box_y;
      q_w_r    <= in_box_width;
      q_h_r    <= in_box_height;
    end
    if (cmd.out_ld) begin
      match_id_r <= cmd.out_match ? rd_data_r.id : '0;
    end
  end

  // closed-interval overlap on both axes
  always_comb begin
    e_x   = coord_ext(rd_data_r.x);
    e_y   = coord_ext(rd_data_r.y);
    e_w   = EW'(rd_data_r.w);
    e_h   = EW'(rd_data_r.h);
    q_x   = coord_ext(q_x_r);
    q_y   = coord_ext(q_y_r);
    q_w   = EW'(q_w_r);
    q_h   = EW'(q_h_r);
    ovl_x = (e_x <= q_x + q_w) && (e_x + e_w >= q_x);
    ovl_y = (e_y <= q_y + q_h) && (e_y + e_h >= q_y);
  end

  assign stat.full  = (cnt_r == CNTW'(MAX_BOXES));
  assign stat.id_eq = (rd_data_r.id == key_id_r);
  assign stat.hit   = ovl_x && ovl_y && !stat.id_eq;
  assign cnt        = cnt_r;
  assign match_id   = match_id_r;

endmodule

>>> src/aabbct_ctrl.sv
// controller: operation sequencing, table walk and result register
module aabbct_ctrl #(
  parameter int MAX_BOXES = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [1:0]                       in_func,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [2:0]                       out_status,
  output logic                             out_last,
  output aabbct_pkg::dp_cmd_t              cmd,
  input  aabbct_pkg::dp_stat_t             stat,
  input  logic [$clog2(MAX_BOXES + 1)-1:0] cnt,
  output logic [(MAX_BOXES > 1 ? $clog2(MAX_BOXES) : 1)-1:0] rd_addr,
  output logic [(MAX_BOXES > 1 ? $clog2(MAX_BOXES) : 1)-1:0] shift_addr
);

  localparam int AW   = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
  localparam int CNTW = $clog2(MAX_BOXES + 1);

  typedef enum logic {
    S_IDLE,
    S_WALK
  } state_t;

  state_t                state_r, state_nxt;
  aabbct_pkg::func_t     op_r, op_nxt;
  logic [CNTW-1:0]       idx_r, idx_nxt;
  logic                  chk_v_r, chk_v_nxt;
  logic [AW-1:0]         chk_addr_r, chk_addr_nxt;
  logic                  found_r, found_nxt;
  logic                  out_valid_r, out_valid_nxt;
  aabbct_pkg::status_t   out_status_r, out_status_nxt;
  logic                  out_last_r, out_last_nxt;
  logic                  out_free;
  logic                  stall;

  assign out_free   = !out_valid_r || out_ready;
  assign in_ready   = (state_r == S_IDLE) && out_free;
  assign rd_addr    = idx_r[AW-1:0];
  assign shift_addr = chk_addr_r - AW'(1);
  // a query hit waits while the previous beat is still unread
  assign stall      = chk_v_r && (op_r == aabbct_pkg::FUNC_QUERY) && stat.hit && !out_free;

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    idx_nxt        = idx_r;
    chk_v_nxt      = chk_v_r;
    chk_addr_nxt   = chk_addr_r;
    found_nxt      = found_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_last_nxt   = out_last_r;
    cmd            = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          unique case (aabbct_pkg::func_t'(in_func))
            aabbct_pkg::FUNC_ADD: begin
              cmd.out_ld    = 1'b1;
              out_valid_nxt = 1'b1;
              out_last_nxt  = 1'b1;
              if (stat.full) begin
                out_status_nxt = aabbct_pkg::ST_FULL;
              end else begin
                out_status_nxt = aabbct_pkg::ST_OK;
                cmd.add_wr     = 1'b1;
                cmd.cnt_inc    = 1'b1;
              end
            end
            aabbct_pkg::FUNC_CLEAR: begin
              cmd.out_ld     = 1'b1;
              cmd.cnt_clr    = 1'b1;
              out_valid_nxt  = 1'b1;
              out_last_nxt   = 1'b1;
              out_status_nxt = aabbct_pkg::ST_OK;
            end
            aabbct_pkg::FUNC_REMOVE, aabbct_pkg::FUNC_QUERY: begin
              cmd.ld_cmd = 1'b1;
              op_nxt     = aabbct_pkg::func_t'(in_func);
              idx_nxt    = '0;
              chk_v_nxt  = 1'b0;
              found_nxt  = 1'b0;
              state_nxt  = S_WALK;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end

      S_WALK: begin
        // check stage: entry held in the read data register
        if (chk_v_r && !stall) begin
          if (op_r == aabbct_pkg::FUNC_QUERY) begin
            if (stat.hit) begin
              cmd.out_ld     = 1'b1;
              cmd.out_match  = 1'b1;
              out_valid_nxt  = 1'b1;
              out_last_nxt   = 1'b0;
              out_status_nxt = aabbct_pkg::ST_OVERLAP;
            end
          end else if (found_r) begin
            // close the gap: entry moves down one slot
            cmd.shift_wr = 1'b1;
          end else if (stat.id_eq) begin
            found_nxt = 1'b1;
          end
        end

        // read stage
        if (!stall) begin
          if (idx_r != cnt) begin
            cmd.rd_en    = 1'b1;
            idx_nxt      = idx_r + CNTW'(1);
            chk_v_nxt    = 1'b1;
            chk_addr_nxt = idx_r[AW-1:0];
          end else begin
            chk_v_nxt = 1'b0;
          end
        end

        // walk drained: final beat
        if (!chk_v_r && (idx_r == cnt) && out_free) begin
          cmd.out_ld    = 1'b1;
          out_valid_nxt = 1'b1;
          out_last_nxt  = 1'b1;
          state_nxt     = S_IDLE;
          if (op_r == aabbct_pkg::FUNC_QUERY) begin
            out_status_nxt = aabbct_pkg::ST_DONE;
          end else if (found_r) begin
            out_status_nxt = aabbct_pkg::ST_OK;
            cmd.cnt_dec    = 1'b1;
          end else begin
            out_status_nxt = aabbct_pkg::ST_NOT_FOUND;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      op_r         <= aabbct_pkg::FUNC_ADD;
      idx_r        <= '0;
      chk_v_r      <= 1'b0;
      chk_addr_r   <= '0;
      found_r      <= 1'b0;
      out_valid_r  <= 1'b0;
      out_status_r <= aabbct_pkg::ST_OK;
      out_last_r   <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      op_r         <= op_nxt;
      idx_r        <= idx_nxt;
      chk_v_r      <= chk_v_nxt;
      chk_addr_r   <= chk_addr_nxt;
      found_r      <= found_nxt;
      out_valid_r  <= out_valid_nxt;
      out_status_r <= out_status_nxt;
      out_last_r   <= out_last_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_last   = out_last_r;

endmodule

>>> src/aabb_collision_table_core.sv
// top level of the axis-aligned box table with overlap query
// Ordered table of up to MAX_BOXES boxes held in a single-port-write,
// single-port-read memory, one entry read per cycle with registered data
// unless a held-up query match beat stalls the walk. Add and clear give
// one beat, registered at acceptance. Remove and query walk the stored
// boxes, one memory read each, and then check the last entry read before
// the final beat; a query also waits while a match beat is held up by the
// result channel. Remove shifts later entries down during the same walk.
// A new item is taken while the last result beat waits, as long as the output
// register is being emptied that cycle. No clearing pass after reset.
module aabb_collision_table_core #(
  parameter int MAX_BOXES  = 32,
  parameter int COORD_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  in_func,
  input  logic [15:0]                 in_box_id,
  input  logic signed [15:0]          in_box_x,
  input  logic signed [15:0]          in_box_y,
  input  logic [15:0]                 in_box_width,
  input  logic [15:0]                 in_box_height,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [2:0]                  out_status,
  output logic [15:0]                 out_match_id,
  output logic                        out_last
);

  localparam int AW   = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
  localparam int CNTW = $clog2(MAX_BOXES + 1);

  aabbct_pkg::dp_cmd_t  cmd;
  aabbct_pkg::dp_stat_t stat;
  logic [CNTW-1:0]      cnt;
  logic [AW-1:0]        rd_addr;
  logic [AW-1:0]        shift_addr;

  aabbct_ctrl #(
    .MAX_BOXES (MAX_BOXES)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_func    (in_func),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_status (out_status),
    .out_last   (out_last),
    .cmd        (cmd),
    .stat       (stat),
    .cnt        (cnt),
    .rd_addr    (rd_addr),
    .shift_addr (shift_addr)
  );

  aabbct_dp #(
    .MAX_BOXES  (MAX_BOXES),
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .rd_addr       (rd_addr),
    .shift_addr    (shift_addr),
    .cnt           (cnt),
    .in_box_id     (in_box_id),
    .in_box_x      (in_box_x),
    .in_box_y      (in_box_y),
    .in_box_width  (in_box_width),
    .in_box_height (in_box_height),
    .match_id      (out_match_id)
  );

`ifndef NO_ASSERTIONS
  // table never holds more than its capacity
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt <= CNTW'(MAX_BOXES))
    else $error("entry count above capacity");

  // append only when there is room
  a_add_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cnt_inc |-> !stat.full)
    else $error("append to a full table");

  // shift write never lands on the slot being read, nor with an append
  a_shift_port: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.shift_wr |-> !cmd.add_wr && (!cmd.rd_en || (rd_addr != shift_addr)))
    else $error("memory port conflict during remove");

  // a count change always comes with a result beat
  a_cnt_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.cnt_inc || cmd.cnt_dec || cmd.cnt_clr) |=> out_valid && out_last)
    else $error("table changed without a final beat");
`endif

endmodule

>>> bench/aabb_collision_table_checker.sv
// box table checker: watches both channels, predicts the results and compares them
`timescale 1ns / 1ps

module aabb_collision_table_checker #(
  parameter int MAX_BOXES = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [1:0]         in_func,
  input  logic [15:0]        in_box_id,
  input  logic signed [15:0] in_box_x,
  input  logic signed [15:0] in_box_y,
  input  logic [15:0]        in_box_width,
  input  logic [15:0]        in_box_height,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [2:0]         out_status,
  input  logic [15:0]        out_match_id,
  input  logic               out_last,
  output int                 fail_count,
  output int                 pending
);

  typedef struct packed {
    aabbct_pkg::status_t status;
    logic [15:0]         match_id;
    logic                last;
  } box_result_t;

  box_result_t        expected_results[$];
  int                 box_count;
  logic [15:0]        box_ids     [MAX_BOXES];
  logic signed [15:0] box_xs      [MAX_BOXES];
  logic signed [15:0] box_ys      [MAX_BOXES];
  logic [15:0]        box_widths  [MAX_BOXES];
  logic [15:0]        box_heights [MAX_BOXES];

  initial begin
    fail_count = 0;
    pending = 0;
    box_count = 0;
  end

  // closed intervals, max formed at full precision
  function automatic bit spans_touch(int amin, int asize, int bmin, int bsize);
    return (amin <= bmin + bsize) && (amin + asize >= bmin);
  endfunction

  function automatic void queue_result(aabbct_pkg::status_t st, logic [15:0] id,
                                       logic last);
    box_result_t r;
    r.status = st;
    r.match_id = id;
    r.last = last;
    expected_results.insert(expected_results.size(), r);
  endfunction

  task automatic predict_table_op(logic [1:0] fn, logic [15:0] id, logic signed [15:0] x,
                                  logic signed [15:0] y, logic [15:0] w, logic [15:0] h);
    int hit;
    hit = -1;
    case (aabbct_pkg::func_t'(fn))
      aabbct_pkg::FUNC_ADD: begin
        if (box_count >= MAX_BOXES) begin
          queue_result(aabbct_pkg::ST_FULL, 16'd0, 1'b1);
        end else begin
          box_ids[box_count] = id;
          box_xs[box_count] = x;
          box_ys[box_count] = y;
          box_widths[box_count] = w;
          box_heights[box_count] = h;
          box_count++;
          queue_result(aabbct_pkg::ST_OK, 16'd0, 1'b1);
        end
      end
      aabbct_pkg::FUNC_REMOVE: begin
        for (int i = 0; i < box_count && hit < 0; i++)
          if (box_ids[i] == id) hit = i;
        if (hit < 0) begin
          queue_result(aabbct_pkg::ST_NOT_FOUND, 16'd0, 1'b1);
        end else begin
          for (int i = hit; i + 1 < box_count; i++) begin
            box_ids[i] = box_ids[i + 1];
            box_xs[i] = box_xs[i + 1];
            box_ys[i] = box_ys[i + 1];
            box_widths[i] = box_widths[i + 1];
            box_heights[i] = box_heights[i + 1];
          end
          box_count--;
          queue_result(aabbct_pkg::ST_OK, 16'd0, 1'b1);
        end
      end
      aabbct_pkg::FUNC_CLEAR: begin
        box_count = 0;
        queue_result(aabbct_pkg::ST_OK, 16'd0, 1'b1);
      end
      default: begin
        for (int i = 0; i < box_count; i++) begin
          if (box_ids[i] != id &&
              spans_touch(int'(box_xs[i]), int'(box_widths[i]), int'(x), int'(w)) &&
              spans_touch(int'(box_ys[i]), int'(box_heights[i]), int'(y), int'(h)))
            queue_result(aabbct_pkg::ST_OVERLAP, box_ids[i], 1'b0);
        end
        queue_result(aabbct_pkg::ST_DONE, 16'd0, 1'b1);
      end
    endcase
  endtask

  always @(posedge clk) begin : watch
    box_result_t want;
    if (!rst_n) begin
      box_count = 0;
      expected_results.delete();
    end else begin
      // result side first: a beat can never belong to an item taken at this edge
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: unexpected result beat status=%0d id=%0d last=%0d",
                     $realtime, out_status, out_match_id, out_last);
        end else begin
          want = expected_results.pop_front();
          if (out_status !== want.status || out_match_id !== want.match_id ||
              out_last !== want.last) begin
            fail_count++;
            if (fail_count <= 10)
              $display("%0t: expected st=%0d id=%0d last=%0d, got st=%0d id=%0d last=%0d",
                       $realtime, want.status, want.match_id, want.last,
                       out_status, out_match_id, out_last);
          end
        end
      end
      if (in_valid && in_ready)
        predict_table_op(in_func, in_box_id, in_box_x, in_box_y, in_box_width, in_box_height);
    end
    pending <= expected_results.size();
  end

endmodule

>>> bench/aabb_collision_table_core_tb.sv
// testbench top for the box table core: stimulus, flow control and verdict
`timescale 1ns / 1ps

module aabb_collision_table_core_tb;

  localparam int MAX_BOXES    = 32;
  localparam int RANDOM_ITEMS = 370;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int HOLD_CYCLES  = 300;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [1:0]         in_func;
  logic [15:0]        in_box_id;
  logic signed [15:0] in_box_x;
  logic signed [15:0] in_box_y;
  logic [15:0]        in_box_width;
  logic [15:0]        in_box_height;
  logic               out_valid;
  logic               out_ready;
  logic [2:0]         out_status;
  logic [15:0]        out_match_id;
  logic               out_last;

  int fail_count;
  int pending;
  int cycle_count;
  bit steady;
  bit hold_req;
  bit hold_taken;
  int hold_left;

  aabb_collision_table_core #(
    .MAX_BOXES  (MAX_BOXES),
    .COORD_BITS (16)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_func       (in_func),
    .in_box_id     (in_box_id),
    .in_box_x      (in_box_x),
    .in_box_y      (in_box_y),
    .in_box_width  (in_box_width),
    .in_box_height (in_box_height),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_status    (out_status),
    .out_match_id  (out_match_id),
    .out_last      (out_last)
  );

  aabb_collision_table_checker #(
    .MAX_BOXES (MAX_BOXES)
  ) checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_func       (in_func),
    .in_box_id     (in_box_id),
    .in_box_x      (in_box_x),
    .in_box_y      (in_box_y),
    .in_box_width  (in_box_width),
    .in_box_height (in_box_height),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_status    (out_status),
    .out_match_id  (out_match_id),
    .out_last      (out_last),
    .fail_count    (fail_count),
    .pending       (pending)
  );

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_func = aabbct_pkg::FUNC_ADD;
    in_box_id = '0;
    in_box_x = '0;
    in_box_y = '0;
    in_box_width = '0;
    in_box_height = '0;
    out_ready = 1'b0;
    cycle_count = 0;
    steady = 1'b0;
    hold_req = 1'b0;
    hold_taken = 1'b0;
    hold_left = 0;
  end

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // result side: random stalls, one long hold-off that lets the table back up
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else if (hold_req && !hold_taken) begin
      hold_taken = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= steady || ($urandom_range(99) >= 27);
    end
  end

  task automatic send_box(aabbct_pkg::func_t fn, logic [15:0] id, logic [15:0] x,
                          logic [15:0] y, logic [15:0] w, logic [15:0] h);
    @(negedge clk);
    while (!steady && $urandom_range(99) < 27) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_func <= fn;
    in_box_id <= id;
    in_box_x <= x;
    in_box_y <= y;
    in_box_width <= w;
    in_box_height <= h;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  initial begin : stimulus
    aabbct_pkg::func_t fn;
    logic [15:0]       id, x, y, w, h;
    int                pick;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty table, extremes, duplicates, touching edges, misses
    send_box(aabbct_pkg::FUNC_QUERY, 16'd5, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF);
    send_box(aabbct_pkg::FUNC_ADD, 16'd1, 16'h8000, 16'h8000, 16'hFFFF, 16'hFFFF);
    send_box(aabbct_pkg::FUNC_ADD, 16'd2, 16'h7FFF, 16'h7FFF, 16'h0000, 16'h0000);
    send_box(aabbct_pkg::FUNC_ADD, 16'd3, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_box(aabbct_pkg::FUNC_ADD, 16'd1, 16'h0064, 16'hFF9C, 16'h0010, 16'h0010);
    send_box(aabbct_pkg::FUNC_ADD, 16'hFFFF, 16'hFFF0, 16'hFFF0, 16'h0010, 16'h0010);
    send_box(aabbct_pkg::FUNC_QUERY, 16'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_box(aabbct_pkg::FUNC_QUERY, 16'd1, 16'h8000, 16'h8000, 16'hFFFF, 16'hFFFF);
    // query whose max edge just meets the point box at the origin
    send_box(aabbct_pkg::FUNC_QUERY, 16'd9, 16'hFFF0, 16'hFFF0, 16'h0010, 16'h0010);
    send_box(aabbct_pkg::FUNC_QUERY, 16'd9, 16'h0001, 16'h0001, 16'h0000, 16'h0000);
    send_box(aabbct_pkg::FUNC_QUERY, 16'd9, 16'h7FFF, 16'h7FFF, 16'hFFFF, 16'hFFFF);
    send_box(aabbct_pkg::FUNC_QUERY, 16'hFFFF, 16'h8000, 16'h8000, 16'h0000, 16'h0000);
    send_box(aabbct_pkg::FUNC_REMOVE, 16'd1, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_box(aabbct_pkg::FUNC_QUERY, 16'd0, 16'h8000, 16'h8000, 16'hFFFF, 16'hFFFF);
    send_box(aabbct_pkg::FUNC_REMOVE, 16'd77, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_box(aabbct_pkg::FUNC_REMOVE, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_box(aabbct_pkg::FUNC_CLEAR, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_box(aabbct_pkg::FUNC_REMOVE, 16'd3, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_box(aabbct_pkg::FUNC_QUERY, 16'd3, 16'h8000, 16'h8000, 16'hFFFF, 16'hFFFF);

    // random: small id pool and clustered boxes so removes hit and queries match
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 100) hold_req = 1'b1;
      steady = (n >= 220 && n < 280);
      pick = $urandom_range(99);
      fn = pick < 50 ? aabbct_pkg::FUNC_ADD :
           pick < 76 ? aabbct_pkg::FUNC_QUERY :
           pick < 99 ? aabbct_pkg::FUNC_REMOVE : aabbct_pkg::FUNC_CLEAR;
      id = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(11));
      if ($urandom_range(99) < 15) begin
        x = 16'($urandom);
        y = 16'($urandom);
        w = 16'($urandom);
        h = 16'($urandom);
      end else begin
        x = 16'($urandom_range(640)) - 16'd320;
        y = 16'($urandom_range(640)) - 16'd320;
        w = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(256));
        h = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(256));
      end
      send_box(fn, id, x, y, w, h);
    end
    @(negedge clk);
    in_valid <= 1'b0;
    steady = 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

>>> aabb_collision_table_core.f
src/aabbct_pkg.sv
src/aabbct_dp.sv
src/aabbct_ctrl.sv
src/aabb_collision_table_core.sv
bench/aabb_collision_table_checker.sv
bench/aabb_collision_table_core_tb.sv
